### hw/rtl/gccl_pkg.sv
// Shared constants, types and the sRGB decode table for the gamma-correct color blend.
package gccl_pkg;

  localparam int LINEAR_BITS  = 12;
  localparam int FACTOR_BITS  = 16;

  localparam int LIN_W        = LINEAR_BITS + 1;
  localparam int T_W          = FACTOR_BITS + 1;
  localparam int LIN_SHIFT    = 16 - LINEAR_BITS;
  localparam int LIN_ROUND    = (LIN_SHIFT == 0) ? 0 : (1 << (LIN_SHIFT - 1));
  localparam int FACTOR_SHIFT = 16 - FACTOR_BITS;

  localparam int NUM_LANES    = 4;
  localparam int SRCH_STEPS   = 8;
  localparam int LANE_STAGES  = 2 + SRCH_STEPS;
  localparam int MERGE_STAGES = 2;
  localparam int NUM_STAGES   = LANE_STAGES + MERGE_STAGES;

  localparam int IN_TDATA_W   = 96;
  localparam int OUT_TDATA_W  = 32;
  localparam int FROM_LSB     = 0;
  localparam int TO_LSB       = 32;
  localparam int BLEND_LSB    = 64;
  localparam int OPAC_LSB     = 81;

  localparam logic [16:0] Q16_ONE      = 17'd65536;
  localparam logic [7:0]  OPACITY_KEEP = 8'hFF;

  typedef logic [7:0]            byte_t;
  typedef logic [LIN_W-1:0]      lin_t;
  typedef logic [T_W-1:0]        factor_t;
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  localparam logic [16:0] DECODE_Q16 [256] = '{
    17'd0, 17'd20, 17'd40, 17'd60, 17'd80, 17'd99, 17'd119, 17'd139,
    17'd159, 17'd179, 17'd199, 17'd219, 17'd241, 17'd264, 17'd288, 17'd313,
    17'd340, 17'd367, 17'd396, 17'd427, 17'd458, 17'd491, 17'd526, 17'd562,
    17'd599, 17'd637, 17'd677, 17'd718, 17'd761, 17'd805, 17'd851, 17'd898,
    17'd947, 17'd997, 17'd1048, 17'd1101, 17'd1156, 17'd1212, 17'd1270, 17'd1330,
    17'd1391, 17'd1453, 17'd1517, 17'd1583, 17'd1651, 17'd1720, 17'd1791, 17'd1863,
    17'd1937, 17'd2013, 17'd2090, 17'd2170, 17'd2250, 17'd2333, 17'd2418, 17'd2504,
    17'd2592, 17'd2681, 17'd2773, 17'd2866, 17'd2961, 17'd3058, 17'd3157, 17'd3258,
    17'd3360, 17'd3464, 17'd3570, 17'd3678, 17'd3788, 17'd3900, 17'd4014, 17'd4129,
    17'd4247, 17'd4366, 17'd4488, 17'd4611, 17'd4736, 17'd4864, 17'd4993, 17'd5124,
    17'd5257, 17'd5392, 17'd5530, 17'd5669, 17'd5810, 17'd5953, 17'd6099, 17'd6246,
    17'd6395, 17'd6547, 17'd6701, 17'd6856, 17'd7014, 17'd7174, 17'd7336, 17'd7500,
    17'd7666, 17'd7834, 17'd8004, 17'd8177, 17'd8352, 17'd8529, 17'd8708, 17'd8889,
    17'd9072, 17'd9258, 17'd9446, 17'd9636, 17'd9828, 17'd10022, 17'd10219, 17'd10418,
    17'd10619, 17'd10822, 17'd11028, 17'd11236, 17'd11446, 17'd11658, 17'd11873, 17'd12090,
    17'd12309, 17'd12531, 17'd12754, 17'd12981, 17'd13209, 17'd13440, 17'd13673, 17'd13909,
    17'd14147, 17'd14387, 17'd14629, 17'd14874, 17'd15122, 17'd15372, 17'd15624, 17'd15878,
    17'd16135, 17'd16394, 17'd16656, 17'd16920, 17'd17187, 17'd17456, 17'd17727, 17'd18001,
    17'd18278, 17'd18556, 17'd18838, 17'd19121, 17'd19408, 17'd19696, 17'd19988, 17'd20281,
    17'd20578, 17'd20876, 17'd21178, 17'd21481, 17'd21788, 17'd22096, 17'd22408, 17'd22722,
    17'd23038, 17'd23357, 17'd23679, 17'd24003, 17'd24329, 17'd24659, 17'd24991, 17'd25325,
    17'd25662, 17'd26002, 17'd26344, 17'd26689, 17'd27036, 17'd27387, 17'd27739, 17'd28095,
    17'd28453, 17'd28813, 17'd29177, 17'd29543, 17'd29911, 17'd30283, 17'd30657, 17'd31033,
    17'd31413, 17'd31795, 17'd32180, 17'd32567, 17'd32957, 17'd33350, 17'd33746, 17'd34144,
    17'd34545, 17'd34949, 17'd35356, 17'd35765, 17'd36177, 17'd36592, 17'd37010, 17'd37430,
    17'd37853, 17'd38279, 17'd38708, 17'd39139, 17'd39574, 17'd40011, 17'd40451, 17'd40893,
    17'd41339, 17'd41787, 17'd42239, 17'd42693, 17'd43150, 17'd43609, 17'd44072, 17'd44537,
    17'd45006, 17'd45477, 17'd45951, 17'd46428, 17'd46908, 17'd47390, 17'd47876, 17'd48365,
    17'd48856, 17'd49350, 17'd49848, 17'd50348, 17'd50851, 17'd51357, 17'd51866, 17'd52378,
    17'd52893, 17'd53411, 17'd53931, 17'd54455, 17'd54982, 17'd55511, 17'd56044, 17'd56580,
    17'd57118, 17'd57660, 17'd58204, 17'd58752, 17'd59303, 17'd59856, 17'd60413, 17'd60972,
    17'd61535, 17'd62101, 17'd62670, 17'd63241, 17'd63816, 17'd64394, 17'd64975, 17'd65536
  };

  // decode one sRGB code to linear Q1.LINEAR_BITS with rounding
  function automatic lin_t lin_of(input byte_t code);
    logic [17:0] sum;
    sum = {1'b0, DECODE_Q16[code]} + 18'(LIN_ROUND);
    return lin_t'(sum >> LIN_SHIFT);
  endfunction

endpackage

### hw/rtl/gamma_correct_color_lerp_unit.sv
// Top level: gamma-correct RGBA blend with alpha override and premultiply.
// Pipeline: 12 register stages (decode, mix, 8 search, 2 merge).
// Throughput: one request per cycle while out_tready does not stall the pipe; four channel lanes run side by side.
// Each stage advances when empty or when its successor advances, so bubbles collapse.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload registers are not reset.
module gamma_correct_color_lerp_unit
  import gccl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] color_from, [63:32] color_to, [80:64] blend_factor, [88:81] opacity, [95:89] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] color_out
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  stage_en_t   en;
  logic [16:0] blend;
  logic [16:0] blend_sat;
  factor_t     t;
  byte_t       codes [NUM_LANES];

  assign blend     = in_tdata[BLEND_LSB +: 17];
  assign blend_sat = (blend > Q16_ONE) ? Q16_ONE : blend;
  assign t         = factor_t'(blend_sat >> FACTOR_SHIFT);

  gccl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .en        (en),
    .in_ready  (in_tready),
    .out_valid (out_tvalid)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    gccl_lane u_lane (
      .clk    (clk),
      .en     (en[LANE_STAGES-1:0]),
      .byte_a (in_tdata[FROM_LSB + 8*i +: 8]),
      .byte_b (in_tdata[TO_LSB + 8*i +: 8]),
      .t      (t),
      .code   (codes[i])
    );
  end

  gccl_merge u_merge (
    .clk       (clk),
    .en        (en),
    .opacity   (in_tdata[OPAC_LSB +: 8]),
    .codes     (codes),
    .color_out (out_tdata)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  a_premult: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:24] <= out_tdata[7:0]) &&
                   (out_tdata[23:16] <= out_tdata[7:0]) &&
                   (out_tdata[15:8]  <= out_tdata[7:0]))
    else $error("color channel exceeds alpha");

endmodule

### hw/rtl/gccl_ctrl.sv
// Stage valid bits and per-stage advance enables for the blend pipeline.
module gccl_ctrl
  import gccl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  output stage_en_t en,
  output logic      in_ready,
  output logic      out_valid
);

  stage_en_t v_r;
  stage_en_t v_nxt;

  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (en[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NUM_STAGES-1];

endmodule

### hw/rtl/gccl_lane.sv
// One color channel: sRGB decode, linear mix, and pipelined inverse-curve search.
module gccl_lane
  import gccl_pkg::*;
(
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] en,
  input  byte_t                  byte_a,
  input  byte_t                  byte_b,
  input  factor_t                t,
  output byte_t                  code
);

  localparam int PROD_W = (LIN_W + 1) + (T_W + 1);

  lin_t    l1_r;
  lin_t    l2_r;
  factor_t t_r;
  lin_t    m_r;
  lin_t    m_nxt;

  logic signed [LIN_W:0]    diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] mix;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      l1_r <= lin_of(byte_a);
      l2_r <= lin_of(byte_b);
      t_r  <= t;
    end
  end

  always_comb begin
    diff  = $signed({1'b0, l2_r}) - $signed({1'b0, l1_r});
    prod  = PROD_W'(diff) * PROD_W'($signed({1'b0, t_r}));
    mix   = PROD_W'($signed({1'b0, l1_r})) + (prod >>> FACTOR_BITS);
    m_nxt = mix[LIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m_r <= m_nxt;
    end
  end

  byte_t k_r   [SRCH_STEPS];
  lin_t  sm_r  [SRCH_STEPS-1];
  byte_t k_in  [SRCH_STEPS];
  lin_t  m_in  [SRCH_STEPS];
  byte_t cand  [SRCH_STEPS];
  byte_t k_nxt [SRCH_STEPS];

  assign k_in[0] = '0;
  assign m_in[0] = m_r;

  for (genvar j = 0; j < SRCH_STEPS; j++) begin : g_srch
    if (j > 0) begin : g_link
      assign k_in[j] = k_r[j-1];
      assign m_in[j] = sm_r[j-1];
    end

    assign cand[j]  = k_in[j] | byte_t'(1 << (SRCH_STEPS - 1 - j));
    assign k_nxt[j] = (lin_of(cand[j]) <= m_in[j]) ? cand[j] : k_in[j];

    always_ff @(posedge clk) begin
      if (en[2+j]) begin
        k_r[j] <= k_nxt[j];
      end
    end

    if (j < SRCH_STEPS - 1) begin : g_m
      always_ff @(posedge clk) begin
        if (en[2+j]) begin
          sm_r[j] <= m_in[j];
        end
      end
    end
  end

  assign code = k_r[SRCH_STEPS-1];

endmodule

### hw/rtl/gccl_merge.sv
// Merge of the four channel codes: alpha override and alpha premultiply.
module gccl_merge
  import gccl_pkg::*;
(
  input  logic                   clk,
  input  stage_en_t              en,
  input  byte_t                  opacity,
  input  byte_t                  codes [NUM_LANES],
  output logic [OUT_TDATA_W-1:0] color_out
);

  byte_t       op_r   [LANE_STAGES];
  byte_t       a_nxt;
  byte_t       a_r;
  logic [15:0] prod_nxt [NUM_LANES-1];
  logic [15:0] prod_r   [NUM_LANES-1];
  logic [16:0] qsum     [NUM_LANES-1];
  logic [OUT_TDATA_W-1:0] color_nxt;
  logic [OUT_TDATA_W-1:0] color_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      op_r[0] <= opacity;
    end
  end

  for (genvar i = 1; i < LANE_STAGES; i++) begin : g_op
    always_ff @(posedge clk) begin
      if (en[i]) begin
        op_r[i] <= op_r[i-1];
      end
    end
  end

  always_comb begin
    a_nxt = (op_r[LANE_STAGES-1] != OPACITY_KEEP) ? op_r[LANE_STAGES-1] : codes[0];
    for (int i = 1; i < NUM_LANES; i++) begin
      prod_nxt[i-1] = 16'(codes[i]) * 16'(a_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (en[LANE_STAGES]) begin
      a_r    <= a_nxt;
      prod_r <= prod_nxt;
    end
  end

  // divide by 255: exact for all products of two bytes
  always_comb begin
    color_nxt      = '0;
    color_nxt[7:0] = a_r;
    for (int i = 1; i < NUM_LANES; i++) begin
      qsum[i-1] = 17'(prod_r[i-1]) + 17'd1 + 17'(prod_r[i-1][15:8]);
      color_nxt[8*i +: 8] = qsum[i-1][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (en[LANE_STAGES+1]) begin
      color_r <= color_nxt;
    end
  end

  assign color_out = color_r;

endmodule
